### hw/rtl/lpkt_pkg.sv
// ----------------------------------------------------------------------------
// lpkt_pkg: shared definitions for the linear probing key table
// Table geometry, slot entry layout, result codes and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package lpkt_pkg;

  localparam int CAPACITY  = 4096;
  localparam int SLOT_W    = $clog2(CAPACITY);
  localparam int HASH_W    = 32;
  localparam int WORD_W    = 64;
  localparam int KEY_W     = 4 * WORD_W;
  localparam int INDEX_W   = 32;
  localparam int CODE_W    = 8;
  localparam int PAY_W     = INDEX_W + 2 * CODE_W;
  localparam int COUNT_W   = 13;
  // Slot entry: valid flag on top, then the key, then the payload.
  localparam int ENTRY_W   = 1 + KEY_W + PAY_W;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_PRESENT = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef struct packed {
    logic    clear_wr;
    logic    accept;
    logic    step;
    logic    write_entry;
    logic    record;
    logic    take_payload;
    status_t result;
    logic    deliver;
  } lpkt_ctrl_t;

  typedef struct packed {
    logic clear_last;
    logic is_lookup;
    logic slot_empty;
    logic key_match;
    logic probe_last;
    logic out_free;
  } lpkt_stat_t;

endpackage

### hw/rtl/lpkt_in_if.sv
// ----------------------------------------------------------------------------
// lpkt_in_if: request channel of the key table
// Valid/ready channel carrying one insert or lookup command with its key and
// payload.
// ----------------------------------------------------------------------------
interface lpkt_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [63:0] key_word0;
  logic [63:0] key_word1;
  logic [63:0] key_word2;
  logic [63:0] key_word3;
  logic [31:0] pool_index;
  logic [7:0]  protocol;
  logic [7:0]  role;

  modport source (
    output valid, cmd, key_word0, key_word1, key_word2, key_word3,
           pool_index, protocol, role,
    input  ready
  );

  modport sink (
    input  valid, cmd, key_word0, key_word1, key_word2, key_word3,
           pool_index, protocol, role,
    output ready
  );
endinterface

### hw/rtl/lpkt_out_if.sv
// ----------------------------------------------------------------------------
// lpkt_out_if: response channel of the key table
// Valid/ready channel carrying the status, found payload and entry count of
// one command.
// ----------------------------------------------------------------------------
interface lpkt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] found_pool_index;
  logic [7:0]  found_protocol;
  logic [7:0]  found_role;
  logic [12:0] entry_count;

  modport source (
    output valid, status, found_pool_index, found_protocol, found_role,
           entry_count,
    input  ready
  );

  modport sink (
    input  valid, status, found_pool_index, found_protocol, found_role,
           entry_count,
    output ready
  );
endinterface

### hw/rtl/lpkt_ram.sv
// ----------------------------------------------------------------------------
// lpkt_ram: generic single-port RAM
// One read or write address per cycle, read data registered.
// ----------------------------------------------------------------------------
module lpkt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### hw/rtl/lpkt_datapath.sv
// ----------------------------------------------------------------------------
// lpkt_datapath: slot memory, probe address and result registers
// Holds the accepted command, walks the probe slot, compares stored keys and
// keeps the response register toward the output channel.
// ----------------------------------------------------------------------------
module lpkt_datapath (
  input  logic                clk,
  input  logic                rst,
  lpkt_in_if.sink             req,
  lpkt_out_if.source          rsp,
  input  lpkt_pkg::lpkt_ctrl_t ctrl,
  output lpkt_pkg::lpkt_stat_t stat
);

  lpkt_pkg::cmd_t                       cmd_r;
  logic [lpkt_pkg::KEY_W-1:0]           key_r;
  logic [lpkt_pkg::PAY_W-1:0]           pay_r;
  logic [lpkt_pkg::SLOT_W-1:0]          probe_slot;
  logic [lpkt_pkg::SLOT_W-1:0]          probe_num;
  logic [lpkt_pkg::SLOT_W-1:0]          clear_idx;
  logic [lpkt_pkg::COUNT_W-1:0]         entry_count;
  lpkt_pkg::status_t                    res_status;
  logic [lpkt_pkg::PAY_W-1:0]           res_pay;
  logic                                 out_valid;
  lpkt_pkg::status_t                    out_status;
  logic [lpkt_pkg::PAY_W-1:0]           out_pay;
  logic [lpkt_pkg::COUNT_W-1:0]         out_count;

  logic                                 ram_we;
  logic [lpkt_pkg::SLOT_W-1:0]          ram_addr;
  logic [lpkt_pkg::ENTRY_W-1:0]         ram_wdata;
  logic [lpkt_pkg::ENTRY_W-1:0]         ram_rdata;
  logic [lpkt_pkg::SLOT_W-1:0]          home_slot;
  logic [lpkt_pkg::HASH_W-1:0]          hash;

  assign hash      = req.key_word0[lpkt_pkg::HASH_W-1:0];
  assign home_slot = lpkt_pkg::SLOT_W'(hash % lpkt_pkg::CAPACITY);

  assign ram_we    = ctrl.clear_wr | ctrl.write_entry;
  assign ram_addr  = ctrl.clear_wr ? clear_idx : probe_slot;
  assign ram_wdata = ctrl.clear_wr ? '0 : {1'b1, key_r, pay_r};

  lpkt_ram #(
    .WIDTH (lpkt_pkg::ENTRY_W),
    .DEPTH (lpkt_pkg::CAPACITY)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign stat.clear_last = (clear_idx == lpkt_pkg::SLOT_W'(lpkt_pkg::CAPACITY - 1));
  assign stat.is_lookup  = (cmd_r == lpkt_pkg::CMD_LOOKUP);
  assign stat.slot_empty = ~ram_rdata[lpkt_pkg::ENTRY_W-1];
  assign stat.key_match  = (ram_rdata[lpkt_pkg::PAY_W +: lpkt_pkg::KEY_W] == key_r);
  assign stat.probe_last = (probe_num == lpkt_pkg::SLOT_W'(lpkt_pkg::CAPACITY - 1));
  assign stat.out_free   = ~out_valid | rsp.ready;

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      cmd_r      <= lpkt_pkg::cmd_t'(req.cmd);
      key_r      <= {req.key_word3, req.key_word2, req.key_word1, req.key_word0};
      pay_r      <= {req.role, req.protocol, req.pool_index};
      probe_slot <= home_slot;
      probe_num  <= '0;
    end else if (ctrl.step) begin
      // The capacity is a power of two, so the slot address wraps by itself.
      probe_slot <= probe_slot + 1'b1;
      probe_num  <= probe_num + 1'b1;
    end
    if (ctrl.record) begin
      res_status <= ctrl.result;
      res_pay    <= ctrl.take_payload ? ram_rdata[lpkt_pkg::PAY_W-1:0] : '0;
    end
    if (ctrl.deliver) begin
      out_status <= res_status;
      out_pay    <= res_pay;
      out_count  <= entry_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_idx   <= '0;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (ctrl.clear_wr) begin
        clear_idx <= clear_idx + 1'b1;
      end
      if (ctrl.write_entry) begin
        entry_count <= entry_count + 1'b1;
      end
      if (ctrl.deliver) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.status           = out_status;
  assign rsp.found_pool_index = out_pay[lpkt_pkg::INDEX_W-1:0];
  assign rsp.found_protocol   = out_pay[lpkt_pkg::INDEX_W +: lpkt_pkg::CODE_W];
  assign rsp.found_role       = out_pay[lpkt_pkg::INDEX_W + lpkt_pkg::CODE_W +: lpkt_pkg::CODE_W];
  assign rsp.entry_count      = out_count;

endmodule

### hw/rtl/lpkt_ctrl.sv
// ----------------------------------------------------------------------------
// lpkt_ctrl: probe sequencer of the key table
// Clears the slot memory after reset, then for each command reads slots in
// probe order and decides the outcome from the datapath status.
// ----------------------------------------------------------------------------
module lpkt_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  lpkt_pkg::lpkt_stat_t stat,
  output lpkt_pkg::lpkt_ctrl_t ctrl
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    ctrl       = '0;
    ctrl.result = lpkt_pkg::ST_OK;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        ctrl.clear_wr = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          ctrl.accept = 1'b1;
          state_next  = S_READ;
        end
      end
      S_READ: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        priority if (stat.slot_empty) begin
          ctrl.record = 1'b1;
          if (stat.is_lookup) begin
            ctrl.result = lpkt_pkg::ST_MISSING;
          end else begin
            ctrl.write_entry = 1'b1;
            ctrl.result      = lpkt_pkg::ST_OK;
          end
          state_next = S_DONE;
        end else if (stat.key_match) begin
          ctrl.record = 1'b1;
          if (stat.is_lookup) begin
            ctrl.result       = lpkt_pkg::ST_OK;
            ctrl.take_payload = 1'b1;
          end else begin
            ctrl.result = lpkt_pkg::ST_PRESENT;
          end
          state_next = S_DONE;
        end else if (stat.probe_last) begin
          // Every slot was probed without a match or a free slot.
          ctrl.record = 1'b1;
          ctrl.result = stat.is_lookup ? lpkt_pkg::ST_MISSING : lpkt_pkg::ST_FULL;
          state_next  = S_DONE;
        end else begin
          ctrl.step  = 1'b1;
          state_next = S_READ;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          ctrl.deliver = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      req_ready <= 1'b0;
    end else begin
      state     <= state_next;
      req_ready <= (state_next == S_IDLE);
    end
  end

endmodule

### hw/rtl/linear_probe_key_table.sv
// ----------------------------------------------------------------------------
// linear_probe_key_table: open addressing key table with linear probing
//
//   Channel  Role      Carries
//   req      sink      cmd, 256-bit key, pool index, protocol, role
//   rsp      source    status, found payload, entry count
//
// An item is accepted in the idle state, then each slot probed passes a read
// state and a check state, each one read of the single-port slot RAM and one
// key compare; the done state hands the result to the response register.
// No new request is taken before that. After reset the slot RAM is cleared
// one slot a cycle, and no request is taken until that sweep ends. A stalled
// response holds the next result until the response register is free.
// ----------------------------------------------------------------------------
module linear_probe_key_table (
  input  logic       clk,
  input  logic       rst,
  lpkt_in_if.sink    req,
  lpkt_out_if.source rsp
);

  lpkt_pkg::lpkt_ctrl_t ctrl;
  lpkt_pkg::lpkt_stat_t stat;
  logic                 ready;

  assign req.ready = ready;

  lpkt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  lpkt_datapath u_datapath (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .ctrl (ctrl),
    .stat (stat)
  );

endmodule

### dv/tb_linear_probe_key_table.sv
// ----------------------------------------------------------------------------
// tb_linear_probe_key_table: self-checking testbench of the key table
// A table of directed commands covers the empty table, extreme keys and
// payloads, wrap-around probing, duplicate inserts and near-miss lookups.
// Random traffic then mixes hits, near misses and clustered homes under
// several idling patterns. Each response is compared with a behavioral model
// of the table in the testbench, or with the expected value of a typed row.
// ----------------------------------------------------------------------------
module tb_linear_probe_key_table;

  // The longest quiet stretch of a correct run is a probe of the whole full
  // table or the slot sweep after reset.
  localparam int QUIET_LIMIT  = 50000;
  localparam int RANDOM_ITEMS = 182;
  localparam int DRAIN_CYCLES = 40;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    lpkt_pkg::cmd_t cmd;
    logic [63:0]    key_word3;
    logic [63:0]    key_word2;
    logic [63:0]    key_word1;
    logic [63:0]    key_word0;
    logic [31:0]    pool_index;
    logic [7:0]     protocol;
    logic [7:0]     role;
  } req_item_t;

  typedef struct packed {
    lpkt_pkg::status_t status;
    logic [31:0]       found_pool_index;
    logic [7:0]        found_protocol;
    logic [7:0]        found_role;
    logic [12:0]       entry_count;
  } rsp_item_t;

  typedef struct packed {
    req_item_t stim;
    bit        typed;
    rsp_item_t want;
  } dir_row_t;

  localparam logic [63:0] ONES = '1;
  localparam logic [63:0] ALT0 = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [63:0] ALT1 = 64'h5555_5555_5555_5555;
  localparam logic [63:0] TOPW = 64'h0000_0000_0000_0FFF;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lpkt_in_if  req_ch ();
  lpkt_out_if rsp_ch ();

  linear_probe_key_table i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model of the table contents.
  bit                         slot_used [lpkt_pkg::CAPACITY];
  logic [lpkt_pkg::KEY_W-1:0] slot_key  [lpkt_pkg::CAPACITY];
  logic [lpkt_pkg::PAY_W-1:0] slot_pay  [lpkt_pkg::CAPACITY];
  int unsigned                occupancy;
  logic [lpkt_pkg::KEY_W-1:0] stored_keys[$];

  rsp_item_t  pending_rsp[$];
  dir_row_t   directed_rows[$];
  idle_mode_t traffic_mode = IDLE_NONE;
  int         mismatches = 0;
  int         quiet_cycles = 0;

  function automatic rsp_item_t table_apply(input req_item_t it);
    logic [lpkt_pkg::KEY_W-1:0] k;
    int unsigned                home;
    int unsigned                s;
    rsp_item_t                  r;
    k    = {it.key_word3, it.key_word2, it.key_word1, it.key_word0};
    home = it.key_word0[31:0] % lpkt_pkg::CAPACITY;
    r    = '0;
    r.status = (it.cmd == lpkt_pkg::CMD_LOOKUP) ? lpkt_pkg::ST_MISSING : lpkt_pkg::ST_FULL;
    for (int n = 0; n < lpkt_pkg::CAPACITY; n++) begin
      s = (home + n) % lpkt_pkg::CAPACITY;
      if (!slot_used[s]) begin
        if (it.cmd == lpkt_pkg::CMD_INSERT) begin
          slot_used[s] = 1'b1;
          slot_key[s]  = k;
          slot_pay[s]  = {it.role, it.protocol, it.pool_index};
          occupancy++;
          stored_keys.push_back(k);
          r.status = lpkt_pkg::ST_OK;
        end
        break;
      end
      if (slot_key[s] == k) begin
        if (it.cmd == lpkt_pkg::CMD_LOOKUP) begin
          {r.found_role, r.found_protocol, r.found_pool_index} = slot_pay[s];
          r.status = lpkt_pkg::ST_OK;
        end else begin
          r.status = lpkt_pkg::ST_PRESENT;
        end
        break;
      end
    end
    r.entry_count = occupancy[12:0];
    return r;
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic req_item_t make_req(input lpkt_pkg::cmd_t c,
                                         input logic [63:0] w0, w1, w2, w3,
                                         input logic [31:0] pi, input logic [7:0] pr, ro);
    req_item_t it;
    it.cmd        = c;
    it.key_word0  = w0;
    it.key_word1  = w1;
    it.key_word2  = w2;
    it.key_word3  = w3;
    it.pool_index = pi;
    it.protocol   = pr;
    it.role       = ro;
    return it;
  endfunction

  task automatic add_row(input req_item_t it, input bit typed, input lpkt_pkg::status_t st,
                         input logic [31:0] fpi, input logic [7:0] fpr, fro,
                         input logic [12:0] cnt);
    dir_row_t row;
    row.stim  = it;
    row.typed = typed;
    row.want  = {st, fpi, fpr, fro, cnt};
    directed_rows.push_back(row);
  endtask

  function automatic req_item_t random_request();
    req_item_t                  it;
    logic [lpkt_pkg::KEY_W-1:0] k;
    logic [31:0]                h;
    int                         pick;
    int                         w;
    pick = $urandom_range(99);
    if (pick < 45 && stored_keys.size() > 0) begin
      k = stored_keys[$urandom_range(stored_keys.size() - 1)];
      if (pick >= 30) begin
        // Near miss: one bit off, with the hash bits of word 0 kept so the
        // probe walks the same run of slots.
        w = $urandom_range(3);
        if (w == 0) k[32 + $urandom_range(31)] ^= 1'b1;
        else        k[w * 64 + $urandom_range(63)] ^= 1'b1;
      end
    end else begin
      k = {rand_word(), rand_word(), rand_word(), rand_word()};
      if (pick < 70) begin
        // Crowd the homes around the top of the table to build a cluster
        // that wraps past the last slot.
        h = k[31:0];
        h = h - (h % lpkt_pkg::CAPACITY) +
            ((lpkt_pkg::CAPACITY - 6 + $urandom_range(11)) % lpkt_pkg::CAPACITY);
        k[31:0] = h;
      end
    end
    it = make_req($urandom_range(1) ? lpkt_pkg::CMD_LOOKUP : lpkt_pkg::CMD_INSERT,
                  k[63:0], k[127:64], k[191:128], k[255:192],
                  $urandom, 8'($urandom_range(255)), 8'($urandom_range(255)));
    return it;
  endfunction

  // Presents one command and returns at the edge of its transfer.
  task automatic drive_request(input req_item_t it, input bit typed, input rsp_item_t want);
    int        pct;
    int        gap;
    rsp_item_t exp;
    pct = (traffic_mode == IDLE_SENDER) ? 61 : (traffic_mode == IDLE_BOTH) ? 15 : 0;
    gap = 0;
    while ($urandom_range(99) < pct) gap++;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.cmd        <= it.cmd;
    req_ch.key_word0  <= it.key_word0;
    req_ch.key_word1  <= it.key_word1;
    req_ch.key_word2  <= it.key_word2;
    req_ch.key_word3  <= it.key_word3;
    req_ch.pool_index <= it.pool_index;
    req_ch.protocol   <= it.protocol;
    req_ch.role       <= it.role;
    do @(posedge clk); while (!req_ch.ready);
    exp = table_apply(it);
    pending_rsp.push_back(typed ? want : exp);
  endtask

  always @(posedge clk) begin
    case (traffic_mode)
      IDLE_RECEIVER: rsp_ch.ready <= ($urandom_range(99) >= 61);
      IDLE_BOTH:     rsp_ch.ready <= ($urandom_range(99) >= 15);
      default:       rsp_ch.ready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    rsp_item_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("response transfer with no command outstanding");
        mismatches++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
          mismatches++;
        end
        if (rsp_ch.found_pool_index !== want.found_pool_index) begin
          $error("found_pool_index: expected %h, got %h",
                 want.found_pool_index, rsp_ch.found_pool_index);
          mismatches++;
        end
        if (rsp_ch.found_protocol !== want.found_protocol) begin
          $error("found_protocol: expected %h, got %h",
                 want.found_protocol, rsp_ch.found_protocol);
          mismatches++;
        end
        if (rsp_ch.found_role !== want.found_role) begin
          $error("found_role: expected %h, got %h", want.found_role, rsp_ch.found_role);
          mismatches++;
        end
        if (rsp_ch.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, rsp_ch.entry_count);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_linear_probe_key_table NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    req_ch.valid      = 1'b0;
    req_ch.cmd        = lpkt_pkg::CMD_INSERT;
    req_ch.key_word0  = '0;
    req_ch.key_word1  = '0;
    req_ch.key_word2  = '0;
    req_ch.key_word3  = '0;
    req_ch.pool_index = '0;
    req_ch.protocol   = '0;
    req_ch.role       = '0;

    add_row(make_req(lpkt_pkg::CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 0),
            1, lpkt_pkg::ST_MISSING, 0, 0, 0, 0);
    add_row(make_req(lpkt_pkg::CMD_LOOKUP, ONES, ONES, ONES, ONES, '1, '1, '1),
            1, lpkt_pkg::ST_MISSING, 0, 0, 0, 0);
    add_row(make_req(lpkt_pkg::CMD_INSERT, 0, 0, 0, 0, '1, '1, '1),
            1, lpkt_pkg::ST_OK, 0, 0, 0, 1);
    add_row(make_req(lpkt_pkg::CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 0),
            1, lpkt_pkg::ST_OK, '1, '1, '1, 1);
    add_row(make_req(lpkt_pkg::CMD_INSERT, ONES, ONES, ONES, ONES, 0, 0, 0),
            1, lpkt_pkg::ST_OK, 0, 0, 0, 2);
    // Home in the last slot, so the probe wraps to the start of the table.
    add_row(make_req(lpkt_pkg::CMD_INSERT, TOPW, ALT0, ALT1, ALT0, 32'h1234_5678, 8'h5A, 8'hA5),
            0, lpkt_pkg::ST_OK, 0, 0, 0, 0);
    add_row(make_req(lpkt_pkg::CMD_LOOKUP, TOPW, ALT0, ALT1, ALT0, 0, 0, 0),
            0, lpkt_pkg::ST_OK, 0, 0, 0, 0);
    add_row(make_req(lpkt_pkg::CMD_INSERT, 0, 0, 0, 0, 32'h1, 8'h2, 8'h3),
            1, lpkt_pkg::ST_PRESENT, 0, 0, 0, 3);
    add_row(make_req(lpkt_pkg::CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 0),
            0, lpkt_pkg::ST_OK, 0, 0, 0, 0);
    add_row(make_req(lpkt_pkg::CMD_LOOKUP, ONES, ONES, ONES, {1'b0, ONES[62:0]}, 0, 0, 0),
            0, lpkt_pkg::ST_OK, 0, 0, 0, 0);
    add_row(make_req(lpkt_pkg::CMD_LOOKUP, {1'b1, TOPW[62:0]}, ALT0, ALT1, ALT0, 0, 0, 0),
            0, lpkt_pkg::ST_OK, 0, 0, 0, 0);
    add_row(make_req(lpkt_pkg::CMD_LOOKUP, TOPW, ALT0 ^ 64'h1, ALT1, ALT0, 0, 0, 0),
            0, lpkt_pkg::ST_OK, 0, 0, 0, 0);
    add_row(make_req(lpkt_pkg::CMD_LOOKUP, TOPW, ALT0, ALT1 ^ ONES, ALT0, 0, 0, 0),
            0, lpkt_pkg::ST_OK, 0, 0, 0, 0);
    add_row(make_req(lpkt_pkg::CMD_LOOKUP, TOPW, ALT0, ALT1, {1'b0, ALT0[62:0]}, 0, 0, 0),
            0, lpkt_pkg::ST_OK, 0, 0, 0, 0);
    add_row(make_req(lpkt_pkg::CMD_INSERT, TOPW, ALT0 ^ 64'h1, ALT1, ALT0, '1, 0, '1),
            0, lpkt_pkg::ST_OK, 0, 0, 0, 0);
    add_row(make_req(lpkt_pkg::CMD_LOOKUP, TOPW, ALT0 ^ 64'h1, ALT1, ALT0, 0, 0, 0),
            0, lpkt_pkg::ST_OK, 0, 0, 0, 0);
    // The payload fields of a lookup must be ignored.
    add_row(make_req(lpkt_pkg::CMD_LOOKUP, TOPW, ALT0, ALT1, ALT0, '1, '1, '1),
            0, lpkt_pkg::ST_OK, 0, 0, 0, 0);
    add_row(make_req(lpkt_pkg::CMD_INSERT, ALT1, ALT0, ALT0, ALT0, 32'hAAAA_5555, 8'hAA, 8'h55),
            0, lpkt_pkg::ST_OK, 0, 0, 0, 0);
    add_row(make_req(lpkt_pkg::CMD_INSERT, ALT0, ALT1, ALT1, ALT1, 32'h5555_AAAA, 8'h55, 8'hAA),
            0, lpkt_pkg::ST_OK, 0, 0, 0, 0);
    add_row(make_req(lpkt_pkg::CMD_LOOKUP, ALT1, ALT0, ALT0, ALT0, 0, 0, 0),
            0, lpkt_pkg::ST_OK, 0, 0, 0, 0);
    add_row(make_req(lpkt_pkg::CMD_LOOKUP, ALT0, ALT1, ALT1, ALT1, 0, 0, 0),
            0, lpkt_pkg::ST_OK, 0, 0, 0, 0);
    add_row(make_req(lpkt_pkg::CMD_INSERT, 64'hFFFF_FFFE, 0, ONES, 0, '1, 0, '1),
            0, lpkt_pkg::ST_OK, 0, 0, 0, 0);
    add_row(make_req(lpkt_pkg::CMD_LOOKUP, ONES, ONES, ONES, ONES, 0, 0, 0),
            0, lpkt_pkg::ST_OK, 0, 0, 0, 0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < directed_rows.size(); i++) begin
      drive_request(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int m = 0; m < 4; m++) begin
      traffic_mode = idle_mode_t'(m);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
        drive_request(random_request(), 0, '0);
      end
    end

    req_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_linear_probe_key_table OK");
    end else begin
      $display("tb_linear_probe_key_table NOT OK");
    end
    $finish;
  end

endmodule
